// ===== rtl/dap_pkg.sv =====
// shared types, constants and helper functions of the dihedral angle unit
package dap_pkg;

    localparam int CoordW    = 20;
    localparam int NumCoords = 12;
    localparam int DiffW     = 21;
    localparam int ProdW     = 42;
    localparam int NormW     = 43;
    localparam int RedW      = 16;
    localparam int PairW     = 32;
    localparam int DotW      = 33;
    localparam int TpW       = 53;
    localparam int TsW       = 55;
    localparam int SqW       = 64;
    localparam int RootW     = 32;
    localparam int RootSteps = 32;
    localparam int CordW     = 36;
    localparam int AngW      = 25;
    localparam int CordSteps = 22;
    localparam int ShiftW    = 5;
    localparam int PosW      = 6;
    localparam int TorsW     = 16;
    localparam int Deg90     = 2949120;
    localparam int AngleMax  = 23040;
    localparam int RoundBias = 128;
    localparam int RoundSh   = 8;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [DiffW-1:0]  diff_t;
    typedef logic signed [NormW-1:0]  norm_t;
    typedef logic signed [RedW-1:0]   red_t;
    typedef logic signed [DotW-1:0]   dot_t;
    typedef logic signed [CordW-1:0]  cord_t;
    typedef logic signed [AngW-1:0]   ang_t;
    typedef logic signed [TorsW-1:0]  tors_t;

    typedef struct packed {
        logic        valid;
        norm_t [2:0] n1;
        norm_t [2:0] n2;
        diff_t [2:0] bc;
    } norm_bus_t;

    typedef struct packed {
        logic        valid;
        logic        degen;
        red_t [2:0]  p;
        red_t [2:0]  q;
        diff_t [2:0] bc;
    } red_bus_t;

    typedef struct packed {
        logic degen;
        dot_t x;
        logic t_neg;
    } info_t;

    typedef struct packed {
        logic           valid;
        info_t          info;
        logic [SqW-1:0] ss;
    } sq_bus_t;

    typedef struct packed {
        logic             valid;
        info_t            info;
        logic [RootW-1:0] y;
    } root_bus_t;

    function automatic logic [PosW-1:0] msb_pos(input logic [NormW-1:0] m);
        logic [PosW-1:0] pos;
        pos = '0;
        for (int i = 0; i < NormW; i++)
        begin
            if (m[i])
            begin
                pos = PosW'(i);
            end
        end
        return pos;
    endfunction

    function automatic ang_t atan_entry(input int i);
        ang_t a;
        unique case (i)
            0:  a = ang_t'(1474560);
            1:  a = ang_t'(870484);
            2:  a = ang_t'(459940);
            3:  a = ang_t'(233473);
            4:  a = ang_t'(117189);
            5:  a = ang_t'(58652);
            6:  a = ang_t'(29333);
            7:  a = ang_t'(14667);
            8:  a = ang_t'(7334);
            9:  a = ang_t'(3667);
            10: a = ang_t'(1833);
            11: a = ang_t'(917);
            12: a = ang_t'(458);
            13: a = ang_t'(229);
            14: a = ang_t'(115);
            15: a = ang_t'(57);
            16: a = ang_t'(29);
            17: a = ang_t'(14);
            18: a = ang_t'(7);
            19: a = ang_t'(4);
            20: a = ang_t'(2);
            21: a = ang_t'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/dap_normals.sv =====
// difference vectors and plane normals, three pipeline stages
module dap_normals (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  dap_pkg::coord_t [dap_pkg::NumCoords-1:0] coords,
    output dap_pkg::norm_bus_t                   out_bus
);
    import dap_pkg::*;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    diff_t [2:0] ba_reg;
    diff_t [2:0] bc_reg;
    diff_t [2:0] cb_reg;
    diff_t [2:0] cd_reg;
    logic signed [ProdW-1:0] m1a_reg [3];
    logic signed [ProdW-1:0] m1b_reg [3];
    logic signed [ProdW-1:0] m2a_reg [3];
    logic signed [ProdW-1:0] m2b_reg [3];
    diff_t [2:0] bc2_reg;
    norm_t [2:0] n1_reg;
    norm_t [2:0] n2_reg;
    diff_t [2:0] bc3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ba_reg[i] <= diff_t'(coords[i]) - diff_t'(coords[3+i]);
                bc_reg[i] <= diff_t'(coords[6+i]) - diff_t'(coords[3+i]);
                cb_reg[i] <= diff_t'(coords[3+i]) - diff_t'(coords[6+i]);
                cd_reg[i] <= diff_t'(coords[9+i]) - diff_t'(coords[6+i]);
            end
            m1a_reg[0] <= ba_reg[1] * bc_reg[2];
            m1b_reg[0] <= ba_reg[2] * bc_reg[1];
            m1a_reg[1] <= ba_reg[2] * bc_reg[0];
            m1b_reg[1] <= ba_reg[0] * bc_reg[2];
            m1a_reg[2] <= ba_reg[0] * bc_reg[1];
            m1b_reg[2] <= ba_reg[1] * bc_reg[0];
            m2a_reg[0] <= cb_reg[1] * cd_reg[2];
            m2b_reg[0] <= cb_reg[2] * cd_reg[1];
            m2a_reg[1] <= cb_reg[2] * cd_reg[0];
            m2b_reg[1] <= cb_reg[0] * cd_reg[2];
            m2a_reg[2] <= cb_reg[0] * cd_reg[1];
            m2b_reg[2] <= cb_reg[1] * cd_reg[0];
            bc2_reg <= bc_reg;
            for (int i = 0; i < 3; i++)
            begin
                n1_reg[i] <= norm_t'(m1a_reg[i]) - norm_t'(m1b_reg[i]);
                n2_reg[i] <= norm_t'(m2a_reg[i]) - norm_t'(m2b_reg[i]);
            end
            bc3_reg <= bc2_reg;
        end
    end

    always_comb
    begin
        out_bus.valid = s3_valid_reg;
        out_bus.n1    = n1_reg;
        out_bus.n2    = n2_reg;
        out_bus.bc    = bc3_reg;
    end

endmodule

// ===== rtl/dap_reduce.sv =====
// scales each normal down to 16-bit components, three pipeline stages
module dap_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  dap_pkg::norm_bus_t in_bus,
    output dap_pkg::red_bus_t  out_bus
);
    import dap_pkg::*;

    function automatic logic [ShiftW-1:0] red_shift(input logic [NormW-1:0] m);
        logic [PosW-1:0] pos;
        pos = msb_pos(m);
        return (pos >= PosW'(RedW - 1)) ? ShiftW'(pos - PosW'(RedW - 2)) : '0;
    endfunction

    logic [NormW-1:0] mag1_next [3];
    logic [NormW-1:0] mag2_next [3];

    logic r1_valid_reg;
    logic r2_valid_reg;
    logic r3_valid_reg;
    logic [NormW-1:0] mag1_reg [3];
    logic [NormW-1:0] mag2_reg [3];
    logic [2:0] sgn1_reg;
    logic [2:0] sgn2_reg;
    logic [NormW-1:0] or1_reg;
    logic [NormW-1:0] or2_reg;
    diff_t [2:0] bc1_reg;
    logic [NormW-1:0] mag1b_reg [3];
    logic [NormW-1:0] mag2b_reg [3];
    logic [2:0] sgn1b_reg;
    logic [2:0] sgn2b_reg;
    logic [ShiftW-1:0] sh1_reg;
    logic [ShiftW-1:0] sh2_reg;
    logic degen2_reg;
    diff_t [2:0] bc2_reg;
    red_t [2:0] p_reg;
    red_t [2:0] q_reg;
    logic degen3_reg;
    diff_t [2:0] bc3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = in_bus.n1[i][NormW-1] ? -in_bus.n1[i] : in_bus.n1[i];
            mag2_next[i] = in_bus.n2[i][NormW-1] ? -in_bus.n2[i] : in_bus.n2[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_valid_reg <= in_bus.valid;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag1_next[i];
                mag2_reg[i] <= mag2_next[i];
                sgn1_reg[i] <= in_bus.n1[i][NormW-1];
                sgn2_reg[i] <= in_bus.n2[i][NormW-1];
            end
            or1_reg <= mag1_next[0] | mag1_next[1] | mag1_next[2];
            or2_reg <= mag2_next[0] | mag2_next[1] | mag2_next[2];
            bc1_reg <= in_bus.bc;

            mag1b_reg  <= mag1_reg;
            mag2b_reg  <= mag2_reg;
            sgn1b_reg  <= sgn1_reg;
            sgn2b_reg  <= sgn2_reg;
            sh1_reg    <= red_shift(or1_reg);
            sh2_reg    <= red_shift(or2_reg);
            degen2_reg <= (or1_reg == '0) || (or2_reg == '0);
            bc2_reg    <= bc1_reg;

            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= sgn1b_reg[i] ? -red_t'(mag1b_reg[i] >> sh1_reg)
                                         :  red_t'(mag1b_reg[i] >> sh1_reg);
                q_reg[i] <= sgn2b_reg[i] ? -red_t'(mag2b_reg[i] >> sh2_reg)
                                         :  red_t'(mag2b_reg[i] >> sh2_reg);
            end
            degen3_reg <= degen2_reg;
            bc3_reg    <= bc2_reg;
        end
    end

    always_comb
    begin
        out_bus.valid = r3_valid_reg;
        out_bus.degen = degen3_reg;
        out_bus.p     = p_reg;
        out_bus.q     = q_reg;
        out_bus.bc    = bc3_reg;
    end

endmodule

// ===== rtl/dap_vec.sv =====
// dot product, cross product, squared length and axis sign, four pipeline stages
module dap_vec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  dap_pkg::red_bus_t in_bus,
    output dap_pkg::sq_bus_t  out_bus
);
    import dap_pkg::*;

    logic v1_valid_reg;
    logic v2_valid_reg;
    logic v3_valid_reg;
    logic v4_valid_reg;
    logic signed [PairW-1:0] pq_reg [3];
    logic signed [PairW-1:0] wa_reg [3];
    logic signed [PairW-1:0] wb_reg [3];
    logic degen1_reg;
    diff_t [2:0] bc1_reg;
    dot_t x2_reg;
    logic signed [PairW-1:0] w_reg [3];
    logic degen2_reg;
    diff_t [2:0] bc2_reg;
    logic [SqW-1:0] wsq_reg [3];
    logic signed [TpW-1:0] tp_reg [3];
    dot_t x3_reg;
    logic degen3_reg;
    logic [SqW-1:0] ss_reg;
    logic t_neg_reg;
    dot_t x4_reg;
    logic degen4_reg;
    logic signed [TsW-1:0] tsum_next;

    assign tsum_next = TsW'(tp_reg[0]) + TsW'(tp_reg[1]) + TsW'(tp_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
            v3_valid_reg <= 1'b0;
            v4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_valid_reg <= in_bus.valid;
            v2_valid_reg <= v1_valid_reg;
            v3_valid_reg <= v2_valid_reg;
            v4_valid_reg <= v3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pq_reg[i] <= in_bus.p[i] * in_bus.q[i];
            end
            wa_reg[0]  <= in_bus.p[1] * in_bus.q[2];
            wb_reg[0]  <= in_bus.p[2] * in_bus.q[1];
            wa_reg[1]  <= in_bus.p[2] * in_bus.q[0];
            wb_reg[1]  <= in_bus.p[0] * in_bus.q[2];
            wa_reg[2]  <= in_bus.p[0] * in_bus.q[1];
            wb_reg[2]  <= in_bus.p[1] * in_bus.q[0];
            degen1_reg <= in_bus.degen;
            bc1_reg    <= in_bus.bc;

            x2_reg <= dot_t'(pq_reg[0]) + dot_t'(pq_reg[1]) + dot_t'(pq_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= wa_reg[i] - wb_reg[i];
            end
            degen2_reg <= degen1_reg;
            bc2_reg    <= bc1_reg;

            for (int i = 0; i < 3; i++)
            begin
                wsq_reg[i] <= w_reg[i] * w_reg[i];
                tp_reg[i]  <= w_reg[i] * bc2_reg[i];
            end
            x3_reg     <= x2_reg;
            degen3_reg <= degen2_reg;

            ss_reg     <= wsq_reg[0] + wsq_reg[1] + wsq_reg[2];
            t_neg_reg  <= tsum_next[TsW-1];
            x4_reg     <= x3_reg;
            degen4_reg <= degen3_reg;
        end
    end

    always_comb
    begin
        out_bus.valid       = v4_valid_reg;
        out_bus.info.degen  = degen4_reg;
        out_bus.info.x      = x4_reg;
        out_bus.info.t_neg  = t_neg_reg;
        out_bus.ss          = ss_reg;
    end

endmodule

// ===== rtl/dap_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module dap_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  dap_pkg::sq_bus_t   in_bus,
    output dap_pkg::root_bus_t out_bus
);
    import dap_pkg::*;

    logic           valid_reg [RootSteps];
    info_t          info_reg  [RootSteps];
    logic [SqW-1:0] v_reg     [RootSteps];
    logic [SqW-1:0] r_reg     [RootSteps];

    for (genvar k = 0; k < RootSteps; k++)
    begin : g_step
        localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * k);
        logic           valid_in;
        info_t          info_in;
        logic [SqW-1:0] v_in;
        logic [SqW-1:0] r_in;
        logic [SqW-1:0] sum;
        logic [SqW-1:0] v_next;
        logic [SqW-1:0] r_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_bus.valid;
            assign info_in  = in_bus.info;
            assign v_in     = in_bus.ss;
            assign r_in     = '0;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[k-1];
            assign info_in  = info_reg[k-1];
            assign v_in     = v_reg[k-1];
            assign r_in     = r_reg[k-1];
        end

        always_comb
        begin
            sum = r_in + Bit;
            if (v_in >= sum)
            begin
                v_next = v_in - sum;
                r_next = (r_in >> 1) + Bit;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                info_reg[k] <= info_in;
                v_reg[k]    <= v_next;
                r_reg[k]    <= r_next;
            end
        end
    end

    always_comb
    begin
        out_bus.valid = valid_reg[RootSteps-1];
        out_bus.info  = info_reg[RootSteps-1];
        out_bus.y     = r_reg[RootSteps-1][RootW-1:0];
    end

endmodule

// ===== rtl/dap_cordic.sv =====
// pipelined vectoring cordic atan2 with rounding, saturation and sign
module dap_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  dap_pkg::root_bus_t in_bus,
    output logic               out_valid,
    output dap_pkg::tors_t     torsion,
    output logic               degenerate
);
    import dap_pkg::*;

    logic [DotW-1:0] xa_next;
    logic [DotW-1:0] ya_next;

    logic c1_valid_reg;
    logic c2_valid_reg;
    logic c3_valid_reg;
    logic [DotW-1:0] xa_reg;
    logic [DotW-1:0] ya_reg;
    logic [DotW-1:0] or_reg;
    logic quad1_reg;
    logic degen1_reg;
    logic tneg1_reg;
    logic [DotW-1:0] xa2_reg;
    logic [DotW-1:0] ya2_reg;
    logic [ShiftW-1:0] k_reg;
    logic zero2_reg;
    logic quad2_reg;
    logic degen2_reg;
    logic tneg2_reg;
    cord_t x3_reg;
    cord_t y3_reg;
    ang_t  z3_reg;
    logic  zero3_reg;
    logic  degen3_reg;
    logic  tneg3_reg;

    logic  valid_reg [CordSteps];
    cord_t x_reg     [CordSteps];
    cord_t y_reg     [CordSteps];
    ang_t  z_reg     [CordSteps];
    logic  zero_reg  [CordSteps];
    logic  degen_reg [CordSteps];
    logic  tneg_reg  [CordSteps];

    logic out_valid_reg;
    tors_t torsion_reg;
    logic degen_out_reg;

    logic [PosW-1:0] pos_next;
    logic [AngW-1:0] zpos_next;
    logic [AngW-1:0] rsum_next;
    logic [AngW-RoundSh-1:0] rnd_next;
    tors_t mag_next;
    tors_t torsion_next;

    always_comb
    begin
        if (in_bus.info.x[DotW-1])
        begin
            xa_next = DotW'(in_bus.y);
            ya_next = -in_bus.info.x;
        end
        else
        begin
            xa_next = in_bus.info.x;
            ya_next = DotW'(in_bus.y);
        end
    end

    assign pos_next = msb_pos(NormW'(or_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= in_bus.valid;
            c2_valid_reg <= c1_valid_reg;
            c3_valid_reg <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg     <= xa_next;
            ya_reg     <= ya_next;
            or_reg     <= xa_next | ya_next;
            quad1_reg  <= in_bus.info.x[DotW-1];
            degen1_reg <= in_bus.info.degen;
            tneg1_reg  <= in_bus.info.t_neg;

            xa2_reg    <= xa_reg;
            ya2_reg    <= ya_reg;
            k_reg      <= (pos_next >= PosW'(30)) ? '0 : ShiftW'(PosW'(30) - pos_next);
            zero2_reg  <= (or_reg == '0);
            quad2_reg  <= quad1_reg;
            degen2_reg <= degen1_reg;
            tneg2_reg  <= tneg1_reg;

            x3_reg     <= cord_t'(xa2_reg) << k_reg;
            y3_reg     <= cord_t'(ya2_reg) << k_reg;
            z3_reg     <= quad2_reg ? ang_t'(Deg90) : '0;
            zero3_reg  <= zero2_reg;
            degen3_reg <= degen2_reg;
            tneg3_reg  <= tneg2_reg;
        end
    end

    for (genvar i = 0; i < CordSteps; i++)
    begin : g_rot
        logic  valid_in;
        cord_t x_in;
        cord_t y_in;
        ang_t  z_in;
        logic  zero_in;
        logic  degen_in;
        logic  tneg_in;
        cord_t x_next;
        cord_t y_next;
        ang_t  z_next;

        if (i == 0)
        begin : g_first
            assign valid_in = c3_valid_reg;
            assign x_in     = x3_reg;
            assign y_in     = y3_reg;
            assign z_in     = z3_reg;
            assign zero_in  = zero3_reg;
            assign degen_in = degen3_reg;
            assign tneg_in  = tneg3_reg;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[i-1];
            assign x_in     = x_reg[i-1];
            assign y_in     = y_reg[i-1];
            assign z_in     = z_reg[i-1];
            assign zero_in  = zero_reg[i-1];
            assign degen_in = degen_reg[i-1];
            assign tneg_in  = tneg_reg[i-1];
        end

        always_comb
        begin
            if (!y_in[CordW-1])
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + atan_entry(i);
            end
            else
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]     <= x_next;
                y_reg[i]     <= y_next;
                z_reg[i]     <= z_next;
                zero_reg[i]  <= zero_in;
                degen_reg[i] <= degen_in;
                tneg_reg[i]  <= tneg_in;
            end
        end
    end

    // clamp at zero, round to 1/128 degree, saturate, apply axis sign; zero if degenerate or zero
    always_comb
    begin
        zpos_next = z_reg[CordSteps-1][AngW-1] ? '0 : z_reg[CordSteps-1];
        rsum_next = zpos_next + AngW'(RoundBias);
        rnd_next  = rsum_next[AngW-1:RoundSh];
        mag_next  = (rnd_next > (AngW-RoundSh)'(AngleMax)) ? tors_t'(AngleMax)
                                                           : tors_t'(rnd_next);
        if (degen_reg[CordSteps-1] || zero_reg[CordSteps-1])
        begin
            torsion_next = '0;
        end
        else if (tneg_reg[CordSteps-1])
        begin
            torsion_next = -mag_next;
        end
        else
        begin
            torsion_next = mag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[CordSteps-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            torsion_reg   <= torsion_next;
            degen_out_reg <= degen_reg[CordSteps-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign torsion    = torsion_reg;
    assign degenerate = degen_out_reg;

endmodule

// ===== rtl/dihedral_angle_from_four_points_unit.sv =====
// top level of the dihedral angle unit: stream ports and pipeline chaining
//
// Takes one word of four points A, B, C, D (Q11.8 coordinates) on the s_axis
// channel and returns the signed torsion angle about the B-C axis on the
// m_axis channel, in 1/128 degree, with a flag for a zero-length plane normal
// (torsion then 0).
// Throughput: one word per cycle; a new word is taken in every cycle in which
// the output register is empty or being read.
// A word taken in passes the normals, their reduction, the vector products, the
// square root (one bit a stage) and the cordic (22 rotation stages) before its
// result shows on m_axis.
// The whole pipeline moves on one enable; when the receiver holds m_axis_tready
// low with a result waiting, every stage holds and s_axis_tready drops, so
// nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes out of reset empty and ready.
module dihedral_angle_from_four_points_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz (20 bits each)
    input  logic [239:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // torsion
    output logic [15:0]  m_axis_tdata,
    // degenerate
    output logic [0:0]   m_axis_tuser
);
    import dap_pkg::*;

    logic en;
    coord_t [NumCoords-1:0] coords;
    norm_bus_t norm_bus;
    red_bus_t  red_bus;
    sq_bus_t   sq_bus;
    root_bus_t root_bus;
    tors_t     torsion;
    logic      degenerate;

    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    always_comb
    begin
        for (int i = 0; i < NumCoords; i++)
        begin
            coords[i] = s_axis_tdata[i*CoordW +: CoordW];
        end
    end

    dap_normals u_normals (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid && s_axis_tready),
        .coords   (coords),
        .out_bus  (norm_bus)
    );

    dap_reduce u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_bus  (norm_bus),
        .out_bus (red_bus)
    );

    dap_vec u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_bus  (red_bus),
        .out_bus (sq_bus)
    );

    dap_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_bus  (sq_bus),
        .out_bus (root_bus)
    );

    dap_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_bus     (root_bus),
        .out_valid  (m_axis_tvalid),
        .torsion    (torsion),
        .degenerate (degenerate)
    );

    assign m_axis_tdata    = torsion;
    assign m_axis_tuser[0] = degenerate;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate word with nonzero torsion");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (int'($signed(m_axis_tdata)) <= AngleMax) &&
                          (int'($signed(m_axis_tdata)) >= -AngleMax))
        else $error("torsion out of range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

endmodule

// ===== tb/dihedral_angle_from_four_points_unit_test.sv =====
// self-checking stream testbench of the dihedral angle unit
module dihedral_angle_from_four_points_unit_test;
    import dap_pkg::*;

    typedef struct {
        logic signed [15:0] torsion;
        logic               degenerate;
    } angle_t;

    typedef logic signed [63:0] s64_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [239:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    logic [239:0] point_words[$];
    angle_t       expected_angles[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off_cycles;
    bit           feed_done;
    int           errors;
    int           quiet_cycles;

    dihedral_angle_from_four_points_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        feed_done = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic s64_t crd(input logic [239:0] w, input int k);
        logic signed [19:0] c;
        c = w[k*20 +: 20];
        return s64_t'(c);
    endfunction

    function automatic s64_t shr_floor(input s64_t v, input int s);
        return v >>> s;
    endfunction

    function automatic void reduce_normal(input s64_t n[3], output s64_t r[3]);
        logic [63:0] m;
        logic [63:0] a;
        int          s;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = n[i] < 0 ? -n[i] : n[i];
            if (a > m)
            begin
                m = a;
            end
        end
        s = 0;
        while ((m >> s) >= 32768)
        begin
            s++;
        end
        for (int i = 0; i < 3; i++)
        begin
            a = n[i] < 0 ? -n[i] : n[i];
            a = a >> s;
            r[i] = n[i] < 0 ? -s64_t'(a) : s64_t'(a);
        end
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic s64_t cordic_atan2(input s64_t y, input s64_t x);
        s64_t cx;
        s64_t cy;
        s64_t z;
        s64_t nx;
        s64_t ny;
        if (x < 0)
        begin
            cx = y;
            cy = -x;
            z = Deg90;
        end
        else
        begin
            cx = x;
            cy = y;
            z = 0;
        end
        if (cx == 0 && cy == 0)
        begin
            return 0;
        end
        while (cx < (s64_t'(1) <<< 30) && cy < (s64_t'(1) <<< 30))
        begin
            cx = cx * 2;
            cy = cy * 2;
        end
        for (int i = 0; i < CordSteps; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + shr_floor(cy, i);
                ny = cy - shr_floor(cx, i);
                z = z + s64_t'(atan_entry(i));
            end
            else
            begin
                nx = cx - shr_floor(cy, i);
                ny = cy + shr_floor(cx, i);
                z = z - s64_t'(atan_entry(i));
            end
            cx = nx;
            cy = ny;
        end
        return z < 0 ? 0 : z;
    endfunction

    function automatic angle_t predict_torsion(input logic [239:0] w);
        s64_t        ba[3];
        s64_t        bc[3];
        s64_t        cb[3];
        s64_t        cd[3];
        s64_t        n1[3];
        s64_t        n2[3];
        s64_t        p[3];
        s64_t        q[3];
        s64_t        wv[3];
        s64_t        x;
        s64_t        t;
        s64_t        ang;
        logic [63:0] ss;
        angle_t      r;
        for (int i = 0; i < 3; i++)
        begin
            ba[i] = crd(w, i) - crd(w, 3 + i);
            bc[i] = crd(w, 6 + i) - crd(w, 3 + i);
            cb[i] = -bc[i];
            cd[i] = crd(w, 9 + i) - crd(w, 6 + i);
        end
        n1[0] = ba[1] * bc[2] - ba[2] * bc[1];
        n1[1] = ba[2] * bc[0] - ba[0] * bc[2];
        n1[2] = ba[0] * bc[1] - ba[1] * bc[0];
        n2[0] = cb[1] * cd[2] - cb[2] * cd[1];
        n2[1] = cb[2] * cd[0] - cb[0] * cd[2];
        n2[2] = cb[0] * cd[1] - cb[1] * cd[0];
        if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
            (n2[0] == 0 && n2[1] == 0 && n2[2] == 0))
        begin
            r.torsion = 0;
            r.degenerate = 1'b1;
            return r;
        end
        reduce_normal(n1, p);
        reduce_normal(n2, q);
        x = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
        wv[0] = p[1] * q[2] - p[2] * q[1];
        wv[1] = p[2] * q[0] - p[0] * q[2];
        wv[2] = p[0] * q[1] - p[1] * q[0];
        ss = wv[0] * wv[0] + wv[1] * wv[1] + wv[2] * wv[2];
        t = wv[0] * bc[0] + wv[1] * bc[1] + wv[2] * bc[2];
        ang = (cordic_atan2(s64_t'(root_floor(ss)), x) + RoundBias) >>> RoundSh;
        if (ang > AngleMax)
        begin
            ang = AngleMax;
        end
        if (t < 0)
        begin
            ang = -ang;
        end
        r.torsion = ang[15:0];
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic logic [239:0] pack_points(input int c[12]);
        logic [239:0] w;
        for (int k = 0; k < 12; k++)
        begin
            w[k*20 +: 20] = c[k][19:0];
        end
        return w;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                expected_angles.push_back(predict_torsion(s_axis_tdata));
            end
            if (point_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= point_words.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        angle_t e;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_angles.size() == 0)
                begin
                    $display("%0t: unexpected word torsion=%0d degenerate=%0b", $time,
                             $signed(m_axis_tdata), m_axis_tuser[0]);
                    errors++;
                end
                else
                begin
                    e = expected_angles.pop_front();
                    if (m_axis_tdata !== e.torsion || m_axis_tuser[0] !== e.degenerate)
                    begin
                        $display("%0t: expected torsion=%0d degenerate=%0b, got %0d %0b",
                                 $time, e.torsion, e.degenerate,
                                 $signed(m_axis_tdata), m_axis_tuser[0]);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            hold_off_cycles > 0)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 5000)
        begin
            $display("dihedral_angle_from_four_points_unit_test: FAIL");
            $finish;
        end
    end

    task automatic add_points(input int c[12]);
        point_words.push_back(pack_points(c));
    endtask

    task automatic add_random(input int n);
        int c[12];
        int mode;
        int base;
        for (int j = 0; j < n; j++)
        begin
            mode = $urandom_range(9);
            for (int k = 0; k < 12; k++)
            begin
                if (mode < 4)
                begin
                    c[k] = $urandom_range(4000) - 2000;
                end
                else if (mode < 7)
                begin
                    c[k] = int'($urandom) >>> 12;
                end
                else if (mode == 7)
                begin
                    c[k] = $urandom_range(1) ? 524287 - $urandom_range(3)
                                             : -524288 + $urandom_range(3);
                end
                else
                begin
                    c[k] = $urandom_range(6) - 3;
                end
            end
            if (mode == 9)
            begin
                // collinear b, c and a or d
                base = $urandom_range(1) ? 0 : 9;
                for (int k = 0; k < 3; k++)
                begin
                    c[base + k] = c[3 + k] + 2 * (c[6 + k] - c[3 + k]);
                end
            end
            add_points(c);
        end
    endtask

    task automatic drain();
        while (point_words.size() > 0 || s_axis_tvalid || expected_angles.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        hold_off_cycles = 0;
        send_idle_pct = 8;
        recv_idle_pct = 79;
        repeat (3) @(posedge clk);
        rst_n <= 1'b0;
        #1 rst_n = 1'b1;
        // right angle, trans, cis, and negative sign
        add_points('{256, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, 256});
        add_points('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, -256, 0});
        add_points('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 256, 0});
        add_points('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, -256});
        // extremes
        add_points('{-524288, -524288, -524288, 524287, 524287, 524287,
                     -524288, 524287, -524288, 524287, -524288, 524287});
        add_points('{524287, -524288, 0, -524288, 0, 524287,
                     0, 524287, -524288, -524288, -524288, 524287});
        add_points('{524287, 524287, 524287, -524288, -524288, -524288,
                     524287, -524288, 524287, 0, 0, -524288});
        // degenerate: all equal, a on the axis, d on the axis, b equals c
        add_points('{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5});
        add_points('{512, 0, 0, 0, 0, 0, 256, 0, 0, 256, 256, 0});
        add_points('{0, 256, 0, 0, 0, 0, 256, 0, 0, -256, 0, 0});
        add_points('{0, 256, 0, 7, 7, 7, 7, 7, 7, 256, 0, 3});
        // torsion on the axis sign boundary and tiny offsets
        add_points('{1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1});
        add_points('{-1, -1, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0});
        add_random(200);
        // long receiver stall while the sender keeps offering
        hold_off_cycles = 300;
        drain();
        // sender pause until everything has come back
        add_random(20);
        drain();
        send_idle_pct = 79;
        recv_idle_pct = 8;
        add_random(200);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(220);
        drain();
        feed_done = 1'b1;
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_angles.size() == 0)
        begin
            $display("dihedral_angle_from_four_points_unit_test: PASS");
        end
        else
        begin
            $display("dihedral_angle_from_four_points_unit_test: FAIL");
        end
        $finish;
    end

endmodule
